FILE: rtl/pgfb_pkg.sv
// Shared types and constants for the page framebuffer LCD writer.
// Holds the request codes, the byte-update operations, the sequencer states
// and the LCD command bytes. It has no dependencies.
`default_nettype none

package pgfb_pkg;

  // Fixed panel geometry: one page byte covers eight rows of one column.
  localparam int unsigned COLUMNS = 64;
  localparam int unsigned COL_W = 6;
  localparam int unsigned OFF_W = 7;

  // LCD command opcodes; the low bits carry the page or the column.
  localparam logic [7:0] CMD_SET_PAGE = 8'b1011_1000;
  localparam logic [7:0] CMD_SET_COLUMN = 8'b0100_0000;

  // Offsets within one page of a refresh: the two command bytes in front of the data, and the last data byte.
  localparam logic [OFF_W-1:0] OFF_SET_PAGE = 7'd0;
  localparam logic [OFF_W-1:0] OFF_SET_COLUMN = 7'd1;
  localparam logic [OFF_W-1:0] OFF_LAST = 7'(COLUMNS + 1);

  // Request codes carried on the input word.
  typedef enum logic [1:0] {
    FUNC_SET_PIXEL = 2'd0,
    FUNC_FILL      = 2'd1,
    FUNC_INVERT    = 2'd2,
    FUNC_REFRESH   = 2'd3
  } func_e;

  // Operation of the shared byte-update unit.
  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_INVERT = 2'd2,
    OP_LOAD   = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FILL   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_MODIFY = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/page_framebuffer_lcd_writer.sv
// Top level of the page framebuffer LCD writer: framebuffer memory,
// shared byte-update unit, sequencer and output register. Uses pgfb_pkg.
`default_nettype none

// Usage
// The slave stream takes requests: tuser selects set pixel, fill, invert or
// refresh step, and tdata carries the pixel column, the pixel row and the
// color. The master stream gives LCD bus words: tdata is the bus byte,
// tuser marks commands and the end of a frame, tlast the final word that a
// request causes.
// A set pixel request reads the byte, updates it in the shared byte unit,
// writes it back and then sends three words (page command, column command,
// data); the read, update and send steps follow one another, and the next
// request is taken only after the last word is in the output register.
// An off-screen pixel is dropped without any bus word.
// A refresh step sends one word: a command goes straight to the send step,
// a data byte is read from memory first.
// Fill writes one memory byte a cycle. Invert runs each byte through the
// single memory port pair in a read step and then a write step.
// After reset the block clears the framebuffer in the same way as a fill,
// with tready low. When the receiver stalls, the word waits in the output
// register and the block holds in its send step.

module page_framebuffer_lcd_writer #(
  parameter int unsigned PAGES = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  // Requests.
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [23:0] s_axis_tdata,  // px[7:0], py[15:8], color[16], zero pad
  input  wire [1:0]  s_axis_tuser,  // func[1:0]
  // LCD bus words.
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,  // bus_byte[7:0]
  output logic [1:0] m_axis_tuser,  // is_command[0], frame_end[1]
  output logic       m_axis_tlast   // last word of the request
);

  import pgfb_pkg::*;

  localparam int unsigned PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned ADDR_W = PAGE_W + COL_W;
  localparam int unsigned DEPTH = PAGES * COLUMNS;
  localparam int unsigned ROWS = PAGES * 8;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);

  // Request fields.
  logic [7:0] px;
  logic [7:0] py;
  logic       color;
  func_e      func;
  logic       on_screen;

  assign px = s_axis_tdata[7:0];
  assign py = s_axis_tdata[15:8];
  assign color = s_axis_tdata[16];
  assign func = func_e'(s_axis_tuser);
  assign on_screen = !px[7] && !px[6] && !py[7] && (py[6:0] < 7'(ROWS));

  // Sequencer and work registers.
  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [7:0]          fill_q, fill_d;
  logic [7:0]          mask_q, mask_d;
  logic [7:0]          byte_q, byte_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [OFF_W-1:0]    off_q, off_d;
  logic [1:0]          cnt_q, cnt_d;

  // Refresh position, kept as page and offset within the page.
  logic [PAGE_W-1:0]   rpage_q, rpage_d;
  logic [OFF_W-1:0]    roff_q, roff_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic                out_cmd_q, out_cmd_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;
  logic                out_fend_q, out_fend_d;
  logic                out_free;

  // Framebuffer memory.
  logic [7:0]          mem [DEPTH];
  logic [7:0]          rd_data_q;
  logic                mem_we;
  logic [7:0]          mem_wdata;

  // Shared byte-update unit.
  logic [7:0]          upd_byte;

  // Next word for the bus.
  logic                emit_cmd;
  logic [7:0]          emit_byte;
  logic                emit_last;
  logic                emit_fend;

  logic                accept;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_byte_q;
  assign m_axis_tuser = {out_fend_q, out_cmd_q};
  assign m_axis_tlast = out_last_q;

  // Memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wdata;
    end
    rd_data_q <= mem[addr_q];
  end

  // Byte update on the word just read.
  always_comb begin
    case (op_q)
      OP_SET:    upd_byte = rd_data_q | mask_q;
      OP_CLEAR:  upd_byte = rd_data_q & ~mask_q;
      OP_INVERT: upd_byte = ~rd_data_q;
      OP_LOAD:   upd_byte = rd_data_q;
      default:   upd_byte = rd_data_q;
    endcase
  end

  // Word selection for set pixel and refresh step.
  always_comb begin
    emit_cmd = 1'b0;
    emit_byte = byte_q;
    emit_last = 1'b1;
    emit_fend = 1'b0;
    if (op_q == OP_LOAD) begin
      if (off_q == OFF_SET_PAGE) begin
        emit_cmd = 1'b1;
        emit_byte = CMD_SET_PAGE | {5'd0, 3'(page_q)};
      end else if (off_q == OFF_SET_COLUMN) begin
        emit_cmd = 1'b1;
        emit_byte = CMD_SET_COLUMN;
      end else begin
        emit_fend = (page_q == PAGE_LAST) && (off_q == OFF_LAST);
      end
    end else begin
      case (cnt_q)
        2'd0: begin
          emit_cmd = 1'b1;
          emit_byte = CMD_SET_PAGE | {5'd0, 3'(page_q)};
          emit_last = 1'b0;
        end
        2'd1: begin
          emit_cmd = 1'b1;
          emit_byte = CMD_SET_COLUMN | {2'd0, col_q};
          emit_last = 1'b0;
        end
        default: begin
          emit_cmd = 1'b0;
          emit_byte = byte_q;
        end
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    op_d = op_q;
    addr_d = addr_q;
    fill_d = fill_q;
    mask_d = mask_q;
    byte_d = byte_q;
    page_d = page_q;
    col_d = col_q;
    off_d = off_q;
    cnt_d = cnt_q;
    rpage_d = rpage_q;
    roff_d = roff_q;
    mem_we = 1'b0;
    mem_wdata = fill_q;

    out_valid_d = out_valid_q && !m_axis_tready;
    out_cmd_d = out_cmd_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_fend_d = out_fend_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = 2'd0;
          case (func)
            FUNC_SET_PIXEL: begin
              if (on_screen) begin
                op_d = color ? OP_SET : OP_CLEAR;
                page_d = py[PAGE_W+2:3];
                col_d = px[COL_W-1:0];
                addr_d = {py[PAGE_W+2:3], px[COL_W-1:0]};
                mask_d = 8'd1 << py[2:0];
                state_d = ST_READ;
              end
            end
            FUNC_FILL: begin
              fill_d = color ? 8'hFF : 8'h00;
              addr_d = '0;
              state_d = ST_FILL;
            end
            FUNC_INVERT: begin
              op_d = OP_INVERT;
              addr_d = '0;
              state_d = ST_READ;
            end
            default: begin
              op_d = OP_LOAD;
              page_d = rpage_q;
              off_d = roff_q;
              addr_d = {rpage_q, COL_W'(roff_q - 7'd2)};
              state_d = (roff_q == OFF_SET_PAGE || roff_q == OFF_SET_COLUMN) ?
                        ST_EMIT : ST_READ;
              if (roff_q == OFF_LAST) begin
                roff_d = '0;
                rpage_d = (rpage_q == PAGE_LAST) ? '0 : rpage_q + 1'b1;
              end else begin
                roff_d = roff_q + 1'b1;
              end
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wdata = fill_q;
        if (addr_q == ADDR_LAST) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_READ: begin
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        mem_we = (op_q != OP_LOAD);
        mem_wdata = upd_byte;
        byte_d = upd_byte;
        if (op_q == OP_INVERT) begin
          if (addr_q == ADDR_LAST) begin
            state_d = ST_IDLE;
          end else begin
            addr_d = addr_q + 1'b1;
            state_d = ST_READ;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cmd_d = emit_cmd;
          out_byte_d = emit_byte;
          out_last_d = emit_last;
          out_fend_d = emit_fend;
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      addr_q <= '0;
      fill_q <= 8'h00;
      op_q <= OP_LOAD;
      cnt_q <= 2'd0;
      rpage_q <= '0;
      roff_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q <= addr_d;
      fill_q <= fill_d;
      op_q <= op_d;
      cnt_q <= cnt_d;
      rpage_q <= rpage_d;
      roff_q <= roff_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    byte_q <= byte_d;
    page_q <= page_d;
    col_q <= col_d;
    off_q <= off_d;
    out_cmd_q <= out_cmd_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_fend_q <= out_fend_d;
  end

endmodule

`default_nettype wire

FILE: dv/lcd_word_board_pkg.sv
// Scoreboard for the page framebuffer LCD writer testbench: a private copy of
// the framebuffer and refresh position, and the queue of LCD words still due.
// Depends on pgfb_pkg for the request codes and the LCD command bytes.
package lcd_word_board_pkg;

  import pgfb_pkg::*;

  // Geometry of the instance under test.
  localparam int unsigned FB_PAGES = 8;
  localparam int unsigned FB_BYTES = FB_PAGES * COLUMNS;
  localparam int unsigned STRIDE = COLUMNS + 2;
  localparam int unsigned SEQ_LEN = FB_PAGES * STRIDE;

  // One word on the LCD bus side.
  typedef struct packed {
    logic       is_command;
    logic [7:0] bus_byte;
    logic       last;
    logic       frame_end;
  } lcd_word_t;

  class lcd_word_board;
    logic [7:0]  frame_bytes [FB_BYTES];
    int unsigned refresh_pos;
    lcd_word_t   expected_q [$];
    int unsigned errors;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      refresh_pos = 0;
      errors = 0;
    endfunction

    local function void push_word(logic is_cmd, logic [7:0] data, logic last, logic fend);
      lcd_word_t w;
      w.is_command = is_cmd;
      w.bus_byte = data;
      w.last = last;
      w.frame_end = fend;
      expected_q.push_back(w);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the shadow framebuffer and queue its words.
    function void note_request(logic [1:0] func, logic [23:0] payload);
      int          x;
      int          y;
      int unsigned page;
      int unsigned idx;
      int unsigned pos;
      int unsigned off;
      logic [7:0]  mask;
      logic        color;
      x = int'($signed(payload[7:0]));
      y = int'($signed(payload[15:8]));
      color = payload[16];
      case (func_e'(func))
        FUNC_SET_PIXEL: begin
          // Off-screen pixels are dropped without any bus traffic.
          if (x >= 0 && x < int'(COLUMNS) && y >= 0 && y < int'(FB_PAGES * 8)) begin
            page = y / 8;
            idx = page * COLUMNS + x;
            mask = 8'h01 << (y % 8);
            if (color) begin
              frame_bytes[idx] = frame_bytes[idx] | mask;
            end else begin
              frame_bytes[idx] = frame_bytes[idx] & ~mask;
            end
            push_word(1'b1, CMD_SET_PAGE | 8'(page & 7), 1'b0, 1'b0);
            push_word(1'b1, CMD_SET_COLUMN | 8'(x & 63), 1'b0, 1'b0);
            push_word(1'b0, frame_bytes[idx], 1'b1, 1'b0);
          end
        end
        FUNC_FILL: begin
          foreach (frame_bytes[i]) frame_bytes[i] = color ? 8'hFF : 8'h00;
        end
        FUNC_INVERT: begin
          foreach (frame_bytes[i]) frame_bytes[i] = ~frame_bytes[i];
        end
        default: begin
          // Refresh: per page a page command, a column command, then the data.
          pos = refresh_pos % SEQ_LEN;
          page = pos / STRIDE;
          off = pos % STRIDE;
          if (off == OFF_SET_PAGE) begin
            push_word(1'b1, CMD_SET_PAGE | 8'(page & 7), 1'b1, 1'b0);
          end else if (off == OFF_SET_COLUMN) begin
            push_word(1'b1, CMD_SET_COLUMN, 1'b1, 1'b0);
          end else begin
            push_word(1'b0, frame_bytes[page * COLUMNS + off - 2], 1'b1,
                      (pos == SEQ_LEN - 1) ? 1'b1 : 1'b0);
          end
          pos++;
          if (pos >= SEQ_LEN) pos = 0;
          refresh_pos = pos;
        end
      endcase
    endfunction

    // Compare one accepted bus word with the oldest word still due.
    function void check_word(lcd_word_t got);
      lcd_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected LCD word: is_command %0d bus_byte 0x%02h last %0d frame_end %0d",
               got.is_command, got.bus_byte, got.last, got.frame_end);
        return;
      end
      want = expected_q.pop_front();
      if (got.is_command !== want.is_command) begin
        errors++;
        $error("is_command: expected %0d, actual %0d", want.is_command, got.is_command);
      end
      if (got.bus_byte !== want.bus_byte) begin
        errors++;
        $error("bus_byte: expected 0x%02h, actual 0x%02h", want.bus_byte, got.bus_byte);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last: expected %0d, actual %0d", want.last, got.last);
      end
      if (got.frame_end !== want.frame_end) begin
        errors++;
        $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
      end
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
// Top-level testbench of the page framebuffer LCD writer: clock, reset,
// request driver, bus receiver and monitor. Uses pgfb_pkg and lcd_word_board_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pgfb_pkg::*;
  import lcd_word_board_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 245;
  // Refresh steps offered while the receiver holds off.
  localparam int unsigned HOLD_ITEMS = 8;
  // Longest silent operation is an invert: a read and a write step per framebuffer byte.
  localparam int unsigned DRAIN_CYCLES = 2 * FB_BYTES + 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // px[7:0], py[15:8], color[16], zero pad
  logic [1:0]  s_axis_tuser = '0;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // bus_byte[7:0]
  logic [1:0]  m_axis_tuser;        // is_command[0], frame_end[1]
  logic        m_axis_tlast;

  lcd_word_board board = new();
  int unsigned   cycle_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   hold_requests = 0;

  page_framebuffer_lcd_writer #(
    .PAGES(FB_PAGES)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Monitor: check bus words and record accepted requests at each rising edge.
  always @(posedge clk_i) begin
    lcd_word_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.is_command = m_axis_tuser[0];
        got.bus_byte = m_axis_tdata;
        got.last = m_axis_tlast;
        got.frame_end = m_axis_tuser[1];
        board.check_word(got);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_request(s_axis_tuser, s_axis_tdata);
      end
    end
  end

  // Receiver: its stall pattern is picked at random from four; a requested hold-off
  // keeps tready low for a long stretch so the block backs up.
  initial begin
    int unsigned mode;
    int unsigned phase;
    int unsigned hold_left;
    int unsigned holds_served;
    mode = 0;
    phase = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (phase % 64 == 0) mode = $urandom_range(0, 3);
      phase++;
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = 1'($urandom_range(0, 1));
          2: m_axis_tready = ($urandom_range(0, 3) == 0);
          default: m_axis_tready = (phase % 7 < 5);
        endcase
      end
    end
  end

  // Offer one request and return once it has been accepted. Requests come in
  // bursts of random length with random gaps in between.
  task automatic send_request(func_e func, logic [7:0] px, logic [7:0] py, logic color);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {7'b0, color, py, px};
    s_axis_tuser = func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_pixel(logic [7:0] px, logic [7:0] py, logic color);
    send_request(FUNC_SET_PIXEL, px, py, color);
  endtask

  // A request with random coordinates, which the block ignores; only fill uses the color.
  task automatic send_plain(func_e func, logic color);
    send_request(func, 8'($urandom), 8'($urandom), color);
  endtask

  // A set-pixel request that lands outside the 64x64 screen.
  task automatic send_off_screen();
    logic [7:0] px;
    logic [7:0] py;
    px = 8'($urandom_range(0, 63));
    py = 8'($urandom_range(0, 63));
    case ($urandom_range(0, 2))
      0: px = 8'($urandom_range(64, 255));
      1: py = 8'($urandom_range(64, 255));
      default: begin
        px = 8'($urandom_range(64, 255));
        py = 8'($urandom_range(64, 255));
      end
    endcase
    send_pixel(px, py, 1'($urandom));
  endtask

  initial begin
    int unsigned count;
    int unsigned pick;
    int unsigned run;
    bit          held;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: start of the refresh sequence on a cleared screen.
    send_plain(FUNC_REFRESH, 1'b0);
    send_plain(FUNC_REFRESH, 1'b1);
    send_plain(FUNC_REFRESH, 1'b0);
    // Corners, two bits of one byte, and clearing.
    send_pixel(8'd0, 8'd0, 1'b1);
    send_pixel(8'd63, 8'd63, 1'b1);
    send_pixel(8'd63, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd63, 1'b1);
    send_pixel(8'd5, 8'd13, 1'b1);
    send_pixel(8'd5, 8'd10, 1'b1);
    send_pixel(8'd0, 8'd0, 1'b0);
    send_pixel(8'd63, 8'd63, 1'b0);
    // Off-screen pixels, negative coordinates included.
    send_pixel(8'd64, 8'd0, 1'b1);
    send_pixel(8'hFF, 8'd5, 1'b1);
    send_pixel(8'd10, 8'd64, 1'b0);
    send_pixel(8'd0, 8'h80, 1'b1);
    send_pixel(8'h7F, 8'h7F, 1'b1);
    send_pixel(8'h80, 8'hFF, 1'b0);
    // Fill, invert and their effect on later pixels and refresh data.
    send_plain(FUNC_FILL, 1'b1);
    send_pixel(8'd20, 8'd30, 1'b0);
    send_plain(FUNC_REFRESH, 1'b1);
    send_plain(FUNC_INVERT, 1'($urandom));
    send_pixel(8'd20, 8'd30, 1'b1);
    send_plain(FUNC_REFRESH, 1'b0);
    send_plain(FUNC_FILL, 1'b0);
    send_plain(FUNC_INVERT, 1'b1);

    // Random part: mostly drawing bursts and refresh runs, some fill and
    // invert, and off-screen noise. Halfway through, the receiver holds off
    // while refresh steps keep coming, so the block backs up.
    count = 0;
    held = 1'b0;
    while (count < RANDOM_ITEMS) begin
      if (!held && count >= RANDOM_ITEMS / 2) begin
        held = 1'b1;
        hold_requests++;
        repeat (HOLD_ITEMS) send_plain(FUNC_REFRESH, 1'($urandom));
        count += HOLD_ITEMS;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        run = $urandom_range(1, 6);
        repeat (run) send_pixel(8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
                                1'($urandom));
        count += run;
      end else if (pick < 55) begin
        send_off_screen();
        count++;
      end else if (pick < 58) begin
        send_plain(FUNC_FILL, 1'($urandom));
        count++;
      end else if (pick < 61) begin
        send_plain(FUNC_INVERT, 1'($urandom));
        count++;
      end else begin
        run = $urandom_range(1, 20);
        repeat (run) send_plain(FUNC_REFRESH, 1'($urandom));
        count += run;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.pending() != 0) begin
      $error("%0d LCD words never arrived", board.pending());
    end
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
